@@ rtl/cosdo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CANopen SDO client package
// Item and result types, request and status codes, and SDO command bytes
// shared by the channels and the client datapath.
// ----------------------------------------------------------------------------
package cosdo_pkg;

    localparam int TimeoutW = 16;
    localparam int ElapsedW = 17;

    // request types
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FRAME = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_SPEED  = 2'd2;

    // transfer status
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ABORT     = 3'd1;
    localparam logic [2:0] ST_WRONG_RSP = 3'd2;
    localparam logic [2:0] ST_WRONG_LEN = 3'd3;
    localparam logic [2:0] ST_TIMEOUT   = 3'd4;

    // SDO command bytes
    localparam logic [7:0] CMD_UPLOAD_REQ = 8'h40;
    localparam logic [7:0] CMD_DNLD_1     = 8'h2F;
    localparam logic [7:0] CMD_DNLD_2     = 8'h2B;
    localparam logic [7:0] CMD_DNLD_4     = 8'h23;
    localparam logic [7:0] CMD_UPLOAD_1   = 8'h4F;
    localparam logic [7:0] CMD_UPLOAD_2   = 8'h4B;
    localparam logic [7:0] CMD_UPLOAD_4   = 8'h43;
    localparam logic [7:0] CMD_DNLD_RSP   = 8'h60;
    localparam logic [7:0] CMD_ABORT      = 8'h80;

    localparam logic [10:0] COB_SDO_RX     = 11'h600;
    localparam logic [3:0]  FC_PDO1_TX     = 4'h3;
    localparam logic [3:0]  FC_SDO_TX      = 4'hB;
    localparam logic [3:0]  FC_SDO_RX      = 4'hC;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd100;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  node_id;
        logic [15:0] obj_index;
        logic [7:0]  obj_subindex;
        logic [2:0]  data_length;
        logic [31:0] write_value;
        logic [10:0] rx_cob_id;
        logic [63:0] rx_payload;
    } t_req;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [10:0] tx_cob_id;
        logic [63:0] tx_payload;
        logic [2:0]  status;
        logic [31:0] read_value;
        logic [15:0] speed_value;
    } t_rsp;

    // pipeline control between input stage, engine and result register
    typedef struct packed {
        logic item_valid;
        logic advance;
    } t_stage_ctl;

endpackage

@@ rtl/cosdo_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CANopen SDO client channels
// Valid/ready channels for request items, result items and the timeout
// register write.
// ----------------------------------------------------------------------------
interface cosdo_req_if import cosdo_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cosdo_rsp_if import cosdo_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface cosdo_cfg_if import cosdo_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TimeoutW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/canopen_sdo_expedited_client.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CANopen expedited SDO client
// Builds SDO request frames, tracks one pending transfer, decodes replies
// and timeouts, and reports PDO1 speed values.
// ----------------------------------------------------------------------------
// Each item passes an input register, a combinational decode against the
// pending-transfer state, and a result register, so its result is registered
// as the item leaves the input register, and one item can be accepted
// every cycle while the result side keeps taking transactions. Items that
// cause no result (idle ticks, unrelated frames) still move through the
// same stage. The timeout register is written through its own channel,
// which is always ready, and is used from the next tick on.
module canopen_sdo_expedited_client import cosdo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cosdo_req_if.sink   i_req,
    cosdo_rsp_if.source o_rsp,
    cosdo_cfg_if.sink   i_cfg
);

    t_stage_ctl ctl;
    t_req       stage_item;
    t_rsp       eng_result;
    logic       eng_has_result;
    logic       out_free;

    // hold the staged item while a result cannot be placed
    assign ctl.advance = out_free;
    assign i_cfg.ready = 1'b1;

    cosdo_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_req.valid),
        .i_item    (i_req.payload),
        .o_ready   (i_req.ready),
        .i_advance (ctl.advance),
        .o_valid   (ctl.item_valid),
        .o_item    (stage_item)
    );

    cosdo_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_item       (stage_item),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .o_has_result (eng_has_result),
        .o_result     (eng_result)
    );

    cosdo_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (ctl.item_valid && ctl.advance && eng_has_result),
        .i_result (eng_result),
        .o_free   (out_free),
        .o_valid  (o_rsp.valid),
        .i_ready  (o_rsp.ready),
        .o_result (o_rsp.payload)
    );

endmodule

@@ rtl/cosdo_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Captures one request item and holds it until the engine consumes it.
// ----------------------------------------------------------------------------
module cosdo_in_reg import cosdo_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_item,
    output logic o_ready,
    input  logic i_advance,
    output logic o_valid,
    output t_req o_item
);

    logic r_valid;
    logic n_valid;
    t_req r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/cosdo_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SDO client engine
// Holds the pending transfer and timeout register, decodes one item per
// cycle unless the stage is held, and forms at most one result.
// ----------------------------------------------------------------------------
module cosdo_engine import cosdo_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_stage_ctl          i_ctl,
    input  t_req                i_item,
    input  logic                i_cfg_we,
    input  logic [TimeoutW-1:0] i_cfg_data,
    output logic                o_has_result,
    output t_rsp                o_result
);

    logic                r_awaiting;
    logic                r_is_write;
    logic [2:0]          r_length;
    logic [23:0]         r_key;
    logic [ElapsedW-1:0] r_elapsed;
    logic [TimeoutW-1:0] r_timeout;

    logic                n_awaiting;
    logic                n_is_write;
    logic [2:0]          n_length;
    logic [23:0]         n_key;
    logic [ElapsedW-1:0] n_elapsed;

    logic [7:0]          rx_cmd;
    logic [23:0]         rx_key;
    logic [31:0]         rx_val;
    logic [3:0]          rx_fc;
    logic [ElapsedW-1:0] elapsed_inc;
    logic                len_ok;
    logic [7:0]          tx_cmd;
    logic [31:0]         tx_data;

    assign rx_cmd = i_item.rx_payload[7:0];
    assign rx_key = i_item.rx_payload[31:8];
    assign rx_val = i_item.rx_payload[63:32];
    assign rx_fc  = i_item.rx_cob_id[10:7];

    // saturate the tick count
    assign elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        len_ok  = 1'b1;
        tx_cmd  = CMD_UPLOAD_REQ;
        tx_data = '0;
        if (i_item.req_type == REQ_WRITE) begin
            unique case (i_item.data_length)
                3'd1: begin
                    tx_cmd  = CMD_DNLD_1;
                    tx_data = {24'd0, i_item.write_value[7:0]};
                end
                3'd2: begin
                    tx_cmd  = CMD_DNLD_2;
                    tx_data = {16'd0, i_item.write_value[15:0]};
                end
                3'd4: begin
                    tx_cmd  = CMD_DNLD_4;
                    tx_data = i_item.write_value;
                end
                default: begin
                    len_ok = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_awaiting   = r_awaiting;
        n_is_write   = r_is_write;
        n_length     = r_length;
        n_key        = r_key;
        n_elapsed    = r_elapsed;
        o_has_result = 1'b0;
        o_result     = '0;

        unique case (i_item.req_type) inside
            REQ_READ, REQ_WRITE: begin
                o_has_result = 1'b1;
                if (!len_ok) begin
                    // bad write length: cancel whatever is pending
                    o_result.result_kind = KIND_DONE;
                    o_result.status      = ST_WRONG_LEN;
                    n_awaiting           = 1'b0;
                end else begin
                    o_result.result_kind = KIND_TX;
                    o_result.tx_cob_id   = COB_SDO_RX + {4'd0, i_item.node_id};
                    o_result.tx_payload  = {tx_data, i_item.obj_subindex,
                                            i_item.obj_index, tx_cmd};
                    n_awaiting = 1'b1;
                    n_is_write = (i_item.req_type == REQ_WRITE);
                    n_length   = i_item.data_length;
                    n_key      = {i_item.obj_subindex, i_item.obj_index};
                    n_elapsed  = '0;
                end
            end
            REQ_TICK: begin
                if (r_awaiting) begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc > {1'b0, r_timeout}) begin
                        o_has_result         = 1'b1;
                        o_result.result_kind = KIND_DONE;
                        o_result.status      = ST_TIMEOUT;
                        n_awaiting           = 1'b0;
                    end
                end
            end
            REQ_FRAME: begin
                if (rx_fc == FC_PDO1_TX) begin
                    o_has_result         = 1'b1;
                    o_result.result_kind = KIND_SPEED;
                    o_result.speed_value = i_item.rx_payload[31:16];
                end else if ((rx_fc == FC_SDO_TX || rx_fc == FC_SDO_RX) && r_awaiting) begin
                    o_has_result         = 1'b1;
                    o_result.result_kind = KIND_DONE;
                    n_awaiting           = 1'b0;
                    if (rx_cmd == CMD_ABORT) begin
                        o_result.status = ST_ABORT;
                    end else if (rx_key != r_key) begin
                        o_result.status = ST_WRONG_RSP;
                    end else if (r_is_write) begin
                        o_result.status = (rx_cmd == CMD_DNLD_RSP) ? ST_OK : ST_WRONG_RSP;
                    end else if (rx_cmd == CMD_UPLOAD_1) begin
                        if (r_length == 3'd1) begin
                            o_result.status     = ST_OK;
                            o_result.read_value = {24'd0, rx_val[7:0]};
                        end else begin
                            o_result.status = ST_WRONG_LEN;
                        end
                    end else if (rx_cmd == CMD_UPLOAD_2) begin
                        if (r_length == 3'd2) begin
                            o_result.status     = ST_OK;
                            o_result.read_value = {16'd0, rx_val[15:0]};
                        end else begin
                            o_result.status = ST_WRONG_LEN;
                        end
                    end else if (rx_cmd == CMD_UPLOAD_4) begin
                        if (r_length == 3'd4) begin
                            o_result.status     = ST_OK;
                            o_result.read_value = rx_val;
                        end else begin
                            o_result.status = ST_WRONG_LEN;
                        end
                    end else begin
                        o_result.status = ST_WRONG_RSP;
                    end
                end
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_is_write <= 1'b0;
            r_length   <= '0;
            r_key      <= '0;
            r_elapsed  <= '0;
        end else if (i_ctl.item_valid && i_ctl.advance) begin
            r_awaiting <= n_awaiting;
            r_is_write <= n_is_write;
            r_length   <= n_length;
            r_key      <= n_key;
            r_elapsed  <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_data;
        end
    end

endmodule

@@ rtl/cosdo_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module cosdo_out_reg import cosdo_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_rsp i_result,
    output logic o_free,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_result
);

    logic r_valid;
    logic n_valid;
    t_rsp r_result;

    // a slot is free if empty or emptied this cycle
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ verif/canopen_sdo_expedited_client_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SDO client result checker
// Watches the request, result and timeout-register channels, predicts the
// result of every accepted request from its own copy of the transfer state,
// and compares each accepted result field by field in order.
// ----------------------------------------------------------------------------
module canopen_sdo_expedited_client_checker import cosdo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cosdo_req_if        i_req,
    cosdo_rsp_if        i_rsp,
    cosdo_cfg_if        i_cfg,
    output int unsigned o_fail_count,
    output int unsigned o_outstanding
);

    logic [TimeoutW-1:0] timeout_limit;
    logic                xfer_busy;
    logic                xfer_is_write;
    logic [2:0]          xfer_length;
    logic [23:0]         xfer_key;
    logic [ElapsedW-1:0] xfer_ticks;

    t_rsp due_results[$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    function automatic t_rsp close_transfer(input logic [2:0] st, input logic [31:0] val);
        t_rsp res;
        res             = '0;
        res.result_kind = KIND_DONE;
        res.status      = st;
        res.read_value  = val;
        xfer_busy       = 1'b0;
        return res;
    endfunction

    // Return 1 when the item yields a result, placed in res.
    function automatic bit client_outcome(input t_req r, output t_rsp res);
        logic [7:0]  cmd;
        logic [63:0] frame;
        logic [3:0]  fc;
        logic [31:0] v;
        res = '0;
        case (r.req_type) inside
            REQ_READ, REQ_WRITE: begin
                frame = '0;
                if (r.req_type == REQ_READ) begin
                    cmd = CMD_UPLOAD_REQ;
                end else begin
                    case (r.data_length)
                        3'd1: begin
                            cmd           = CMD_DNLD_1;
                            frame[39:32]  = r.write_value[7:0];
                        end
                        3'd2: begin
                            cmd           = CMD_DNLD_2;
                            frame[47:32]  = r.write_value[15:0];
                        end
                        3'd4: begin
                            cmd           = CMD_DNLD_4;
                            frame[63:32]  = r.write_value;
                        end
                        default: begin
                            res = close_transfer(ST_WRONG_LEN, '0);
                            return 1'b1;
                        end
                    endcase
                end
                frame[7:0]    = cmd;
                frame[23:8]   = r.obj_index;
                frame[31:24]  = r.obj_subindex;
                xfer_busy     = 1'b1;
                xfer_is_write = (r.req_type == REQ_WRITE);
                xfer_length   = r.data_length;
                xfer_key      = {r.obj_subindex, r.obj_index};
                xfer_ticks    = '0;
                res.result_kind = KIND_TX;
                res.tx_cob_id   = COB_SDO_RX + 11'(r.node_id);
                res.tx_payload  = frame;
                return 1'b1;
            end
            REQ_TICK: begin
                if (!xfer_busy) return 1'b0;
                if (xfer_ticks != '1) xfer_ticks = xfer_ticks + 1'b1;
                if (xfer_ticks > ElapsedW'(timeout_limit)) begin
                    res = close_transfer(ST_TIMEOUT, '0);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                fc = r.rx_cob_id[10:7];
                if (fc == FC_PDO1_TX) begin
                    res.result_kind = KIND_SPEED;
                    res.speed_value = r.rx_payload[31:16];
                    return 1'b1;
                end
                if ((fc == FC_SDO_TX || fc == FC_SDO_RX) && xfer_busy) begin
                    cmd = r.rx_payload[7:0];
                    v   = r.rx_payload[63:32];
                    if (cmd == CMD_ABORT)
                        res = close_transfer(ST_ABORT, '0);
                    else if (r.rx_payload[31:8] != xfer_key)
                        res = close_transfer(ST_WRONG_RSP, '0);
                    else if (xfer_is_write)
                        res = close_transfer((cmd == CMD_DNLD_RSP) ? ST_OK : ST_WRONG_RSP, '0);
                    else if (cmd == CMD_UPLOAD_1 && xfer_length == 3'd1)
                        res = close_transfer(ST_OK, {24'h0, v[7:0]});
                    else if (cmd == CMD_UPLOAD_2 && xfer_length == 3'd2)
                        res = close_transfer(ST_OK, {16'h0, v[15:0]});
                    else if (cmd == CMD_UPLOAD_4 && xfer_length == 3'd4)
                        res = close_transfer(ST_OK, v);
                    else if (cmd == CMD_UPLOAD_1 || cmd == CMD_UPLOAD_2 || cmd == CMD_UPLOAD_4)
                        res = close_transfer(ST_WRONG_LEN, '0);
                    else
                        res = close_transfer(ST_WRONG_RSP, '0);
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        t_rsp predicted;
        if (!i_rst_n) begin
            timeout_limit = TIMEOUT_RESET;
            xfer_busy     = 1'b0;
            xfer_is_write = 1'b0;
            xfer_length   = '0;
            xfer_key      = '0;
            xfer_ticks    = '0;
            due_results.delete();
        end else begin
            // results leave only after their item has passed the input and result registers, so pop first
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.payload;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none actual %h", $time, got);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    compare_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
                    compare_field("tx_cob_id", 64'(want.tx_cob_id), 64'(got.tx_cob_id));
                    compare_field("tx_payload", want.tx_payload, got.tx_payload);
                    compare_field("status", 64'(want.status), 64'(got.status));
                    compare_field("read_value", 64'(want.read_value), 64'(got.read_value));
                    compare_field("speed_value", 64'(want.speed_value), 64'(got.speed_value));
                end
            end
            if (i_cfg.valid && i_cfg.ready) timeout_limit = i_cfg.data;
            if (i_req.valid && i_req.ready) begin
                if (client_outcome(i_req.payload, predicted)) due_results.push_back(predicted);
            end
        end
        o_outstanding = due_results.size();
    end

endmodule

@@ verif/canopen_sdo_expedited_client_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SDO client testbench
// Drives directed and random request, reply, tick and PDO traffic through
// several timeout settings with random stalls on both channels; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module canopen_sdo_expedited_client_test;
    import cosdo_pkg::*;

    localparam int unsigned CycleLimit  = 1_000_000;
    localparam int          DrainCycles = 8;
    localparam int          LongHold    = 300;
    localparam logic [3:0]  FC_OTHER    = 4'h7;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned cycle_count = 0;
    bit          no_gaps = 1'b0;
    bit          long_hold_req = 1'b0;

    cosdo_req_if req_ch();
    cosdo_rsp_if rsp_ch();
    cosdo_cfg_if cfg_ch();

    canopen_sdo_expedited_client dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    canopen_sdo_expedited_client_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .i_cfg         (cfg_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Unused fields carry random bits so the block is seen to ignore them.
    function automatic t_req junk_item(input logic [1:0] kind);
        logic [159:0] bits;
        t_req r;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        r = bits[$bits(t_req)-1:0];
        r.req_type = kind;
        return r;
    endfunction

    function automatic t_req read_item(input logic [6:0] node, input logic [15:0] idx,
                                       input logic [7:0] sub, input logic [2:0] len);
        t_req r;
        r = junk_item(REQ_READ);
        r.node_id      = node;
        r.obj_index    = idx;
        r.obj_subindex = sub;
        r.data_length  = len;
        return r;
    endfunction

    function automatic t_req write_item(input logic [6:0] node, input logic [15:0] idx,
                                        input logic [7:0] sub, input logic [2:0] len,
                                        input logic [31:0] val);
        t_req r;
        r = junk_item(REQ_WRITE);
        r.node_id      = node;
        r.obj_index    = idx;
        r.obj_subindex = sub;
        r.data_length  = len;
        r.write_value  = val;
        return r;
    endfunction

    function automatic t_req frame_item(input logic [10:0] cob, input logic [63:0] pay);
        t_req r;
        r = junk_item(REQ_FRAME);
        r.rx_cob_id  = cob;
        r.rx_payload = pay;
        return r;
    endfunction

    function automatic logic [63:0] sdo_reply(input logic [7:0] cmd, input logic [15:0] idx,
                                              input logic [7:0] sub, input logic [31:0] data);
        return {data, sub, idx, cmd};
    endfunction

    function automatic logic [7:0] upload_cmd(input logic [2:0] len);
        case (len)
            3'd1:    return CMD_UPLOAD_1;
            3'd2:    return CMD_UPLOAD_2;
            default: return CMD_UPLOAD_4;
        endcase
    endfunction

    task automatic send_req(input t_req r);
        int gap;
        int roll;
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55) gap = 0;
        else if (roll < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(5, 30);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every result is out and the pipeline has drained.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TimeoutW-1:0] ticks);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= ticks;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly complete transfers: request, a few ticks, then a reply.
    task automatic run_traffic(input int unsigned n_items);
        int unsigned sent;
        int          roll;
        int          nt;
        logic        is_wr;
        logic [6:0]  node;
        logic [15:0] idx;
        logic [7:0]  sub;
        logic [2:0]  len;
        logic [7:0]  cmd;
        logic [23:0] key;
        logic [10:0] cob;
        t_req        r;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                is_wr = 1'($urandom_range(0, 1));
                node  = 7'($urandom);
                idx   = 16'($urandom);
                sub   = 8'($urandom);
                if ($urandom_range(0, 9) == 0) len = 3'($urandom_range(0, 7));
                else len = 3'(1 << $urandom_range(0, 2));
                if (is_wr) send_req(write_item(node, idx, sub, len, $urandom));
                else send_req(read_item(node, idx, sub, len));
                sent++;
                nt = $urandom_range(0, 5);
                repeat (nt) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_req(frame_item({FC_PDO1_TX, 7'($urandom)}, {$urandom, $urandom}));
                        sent++;
                    end
                    send_req(junk_item(REQ_TICK));
                    sent++;
                end
                if ($urandom_range(0, 99) < 85) begin
                    roll = $urandom_range(0, 99);
                    if (is_wr) begin
                        if (roll < 75) cmd = CMD_DNLD_RSP;
                        else if (roll < 85) cmd = CMD_ABORT;
                        else cmd = 8'($urandom);
                    end else begin
                        if (roll < 70 && (len == 3'd1 || len == 3'd2 || len == 3'd4))
                            cmd = upload_cmd(len);
                        else if (roll < 80) cmd = upload_cmd(3'(1 << $urandom_range(0, 2)));
                        else if (roll < 90) cmd = CMD_ABORT;
                        else cmd = 8'($urandom);
                    end
                    key = {sub, idx};
                    if ($urandom_range(0, 99) < 12) key[5'($urandom_range(0, 23))] ^= 1'b1;
                    if ($urandom_range(0, 1)) cob = {FC_SDO_TX, node};
                    else cob = {FC_SDO_RX, 7'($urandom)};
                    send_req(frame_item(cob, {$urandom, key, cmd}));
                    sent++;
                end
            end else if (roll < 85) begin
                send_req(frame_item({FC_PDO1_TX, 7'($urandom)}, {$urandom, $urandom}));
                sent++;
            end else begin
                r = junk_item(2'($urandom));
                send_req(r);
                sent++;
            end
        end
    endtask

    // Result side: random stalls, long open stretches, and one long hold on request.
    initial begin
        int n;
        int roll;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                rsp_ch.ready <= 1'b0;
                repeat (LongHold) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    rsp_ch.ready <= 1'b1;
                    n = $urandom_range(1, 12);
                end else if (roll < 70) begin
                    rsp_ch.ready <= 1'b1;
                    n = $urandom_range(40, 120);
                end else if (roll < 95) begin
                    rsp_ch.ready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    rsp_ch.ready <= 1'b0;
                    n = $urandom_range(8, 40);
                end
                repeat (n) begin
                    @(posedge i_clk);
                    if (long_hold_req) break;
                end
            end
        end
    end

    initial begin
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= '0;
        i_rst_n        <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, at the reset timeout
        send_req(read_item(7'h00, 16'h0000, 8'h00, 3'd4));
        send_req(frame_item({FC_SDO_TX, 7'h00},
                            sdo_reply(CMD_UPLOAD_4, 16'h0000, 8'h00, 32'hFFFF_FFFF)));
        send_req(write_item(7'h7F, 16'hFFFF, 8'hFF, 3'd1, 32'hFFFF_FFFF));
        send_req(frame_item({FC_SDO_RX, 7'h7F}, sdo_reply(CMD_DNLD_RSP, 16'hFFFF, 8'hFF, '0)));
        send_req(write_item(7'h15, 16'h1234, 8'h56, 3'd2, 32'hA5A5_5A5A));
        send_req(frame_item({FC_SDO_TX, 7'h15}, sdo_reply(CMD_ABORT, 16'h1234, 8'h56, '1)));
        send_req(write_item(7'h2A, 16'h6040, 8'h00, 3'd4, 32'h0102_0304));
        send_req(frame_item({FC_SDO_TX, 7'h2A}, sdo_reply(CMD_UPLOAD_1, 16'h6040, 8'h00, '0)));
        // bad write length cancels the pending read; its reply is then ignored
        send_req(read_item(7'h01, 16'h1000, 8'h01, 3'd1));
        send_req(write_item(7'h01, 16'h1000, 8'h01, 3'd0, 32'hDEAD_BEEF));
        send_req(frame_item({FC_SDO_TX, 7'h01}, sdo_reply(CMD_UPLOAD_1, 16'h1000, 8'h01, '1)));
        send_req(read_item(7'h02, 16'h2000, 8'h02, 3'd1));
        send_req(frame_item({FC_SDO_TX, 7'h02}, sdo_reply(CMD_UPLOAD_2, 16'h2000, 8'h02, '1)));
        // bad read length, superseded by a good one
        send_req(read_item(7'h03, 16'h3000, 8'h03, 3'd7));
        send_req(read_item(7'h04, 16'h4000, 8'h04, 3'd2));
        send_req(frame_item({FC_SDO_TX, 7'h04},
                            sdo_reply(CMD_UPLOAD_2, 16'h4000, 8'h04, 32'h8765_4321)));
        send_req(read_item(7'h05, 16'h5000, 8'h05, 3'd2));
        send_req(frame_item({FC_SDO_TX, 7'h05}, sdo_reply(CMD_UPLOAD_2, 16'h5001, 8'h05, '1)));
        send_req(junk_item(REQ_TICK));
        send_req(frame_item({FC_PDO1_TX, 7'h7F}, 64'hFFFF_FFFF_FFFF_FFFF));
        send_req(frame_item({FC_OTHER, 7'h01}, {$urandom, $urandom}));

        // zero timeout: the first tick ends the transfer
        write_timeout('0);
        send_req(read_item(7'h10, 16'h1018, 8'h01, 3'd4));
        send_req(junk_item(REQ_TICK));
        run_traffic(150);

        // largest timeout, then a moderate one run out in full
        write_timeout('1);
        run_traffic(150);
        write_timeout(16'd40);
        send_req(read_item(7'h11, 16'h6041, 8'h00, 3'd2));
        no_gaps = 1'b1;
        repeat (41) send_req(junk_item(REQ_TICK));
        no_gaps = 1'b0;

        write_timeout(16'd3);
        run_traffic(120);
        // hold off the result side while requests keep coming
        wait_idle();
        long_hold_req = 1'b1;
        no_gaps = 1'b1;
        repeat (40) send_req(read_item(7'($urandom), 16'($urandom), 8'($urandom), 3'd4));
        no_gaps = 1'b0;
        run_traffic(130);

        write_timeout(16'($urandom_range(1, 8)));
        run_traffic(250);

        write_timeout(16'd1);
        run_traffic(200);

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
